// ----- rtl/cdgs_pkg.sv -----
// ----------------------------------------------------------------------------
// cdgs_pkg
// Shared widths, register indexes, configuration and event types, and the
// gain ROM of the clip driven gain stepper.
// ----------------------------------------------------------------------------
package cdgs_pkg;

   localparam int NUM_GAINS_DEF = 20;
   localparam int ROM_DEPTH     = 32;
   localparam int ROM_IDX_W     = 5;
   localparam int SAMPLE_W      = 16;
   localparam int GAIN_W        = 16;
   localparam int MAG_W         = 17;
   localparam int LEVEL_W       = 15;
   localparam int SUM_W         = 24;
   localparam int CNT_W         = 8;
   localparam int HOLD_W        = 16;
   localparam int HIST_W        = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 24;

   localparam logic [LEVEL_W-1:0] CLIP_LEVEL_RST   = 15'd32113;
   localparam logic [SUM_W-1:0]   SUM_THRESH_RST   = 24'd327680;
   localparam logic [CNT_W-1:0]   FRAMES_STEP_RST  = 8'd5;
   localparam logic [HOLD_W-1:0]  HOLD_FRAMES_RST  = 16'd200;
   localparam logic [HIST_W-1:0]  HIST_LIMIT_RST   = 8'd2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CLIP_LEVEL     = 3'd0,
      CSR_SUM_THRESHOLD  = 3'd1,
      CSR_FRAMES_TO_STEP = 3'd2,
      CSR_HOLD_FRAMES    = 3'd3,
      CSR_HISTORY_LIMIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] clip_level;
      logic [SUM_W-1:0]   clip_sum_threshold;
      logic [CNT_W-1:0]   clip_frames_to_step;
      logic [HOLD_W-1:0]  hold_frames;
      logic [HIST_W-1:0]  history_limit;
   } cfg_type;

   // One processed beat as seen by the gain step control.
   typedef struct packed {
      logic fire;
      logic frame_end;
      logic clipped;
   } frame_event_type;

   // 0.9^k rounded to two decimals, unsigned Q1.15.
   localparam logic [GAIN_W-1:0] GAIN_ROM [ROM_DEPTH] = '{
      16'd32768, 16'd29491, 16'd26542, 16'd23921, 16'd21627, 16'd19333, 16'd17367, 16'd15729,
      16'd14090, 16'd12780, 16'd11469, 16'd10158, 16'd9175,  16'd8192,  16'd7537,  16'd6881,
      16'd6226,  16'd5571,  16'd4915,  16'd4588,  16'd3932,  16'd3604,  16'd3277,  16'd2949,
      16'd2621,  16'd2294,  16'd1966,  16'd1966,  16'd1638,  16'd1638,  16'd1311,  16'd1311
   };

   function automatic logic [GAIN_W-1:0] gain_lookup(input logic [ROM_IDX_W-1:0] idx);
      return GAIN_ROM[idx];
   endfunction

endpackage

// ----- rtl/cdgs_if.sv -----
// ----------------------------------------------------------------------------
// cdgs_if
// Valid/ready channels of the clip driven gain stepper: sample input,
// result output and register write.
// ----------------------------------------------------------------------------
interface cdgs_req_if;
   import cdgs_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       frame_end;

   modport source (output valid, output sample, output frame_end, input ready);
   modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface cdgs_rsp_if;
   import cdgs_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_W-1:0]  gained_sample;
   logic [ROM_IDX_W-1:0]        gain_index;
   logic                        frame_clipped;

   modport source (output valid, output gained_sample, output gain_index,
                   output frame_clipped, input ready);
   modport sink   (input valid, input gained_sample, input gain_index,
                   input frame_clipped, output ready);
endinterface

interface cdgs_csr_if;
   import cdgs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/cdgs_csr.sv -----
// ----------------------------------------------------------------------------
// cdgs_csr
// Configuration registers; every write beat is accepted and registered.
// ----------------------------------------------------------------------------
module cdgs_csr (
   input  logic              clock,
   input  logic              reset,
   cdgs_csr_if.sink          csr_bus,
   output cdgs_pkg::cfg_type cfg
);
   import cdgs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_CLIP_LEVEL:     cfg_in.clip_level          = csr_bus.data[LEVEL_W-1:0];
            CSR_SUM_THRESHOLD:  cfg_in.clip_sum_threshold  = csr_bus.data[SUM_W-1:0];
            CSR_FRAMES_TO_STEP: cfg_in.clip_frames_to_step = csr_bus.data[CNT_W-1:0];
            CSR_HOLD_FRAMES:    cfg_in.hold_frames         = csr_bus.data[HOLD_W-1:0];
            CSR_HISTORY_LIMIT:  cfg_in.history_limit       = csr_bus.data[HIST_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_level          <= CLIP_LEVEL_RST;
         cfg_ff.clip_sum_threshold  <= SUM_THRESH_RST;
         cfg_ff.clip_frames_to_step <= FRAMES_STEP_RST;
         cfg_ff.hold_frames         <= HOLD_FRAMES_RST;
         cfg_ff.history_limit       <= HIST_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/cdgs_gain_path.sv -----
// ----------------------------------------------------------------------------
// cdgs_gain_path
// Gain multiply, clip detection and per-frame clipped-magnitude sum.
// ----------------------------------------------------------------------------
module cdgs_gain_path #(
   parameter int NUM_GAINS = cdgs_pkg::NUM_GAINS_DEF,
   localparam int IDX_W    = $clog2(NUM_GAINS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  logic signed [cdgs_pkg::SAMPLE_W-1:0] sample,
   input  logic                                 frame_end,
   input  logic [IDX_W-1:0]                     gain_step,
   input  cdgs_pkg::cfg_type                    cfg,
   output logic signed [cdgs_pkg::SAMPLE_W-1:0] gained_sample,
   output cdgs_pkg::frame_event_type            frame_event
);
   import cdgs_pkg::*;

   localparam int PROD_W = MAG_W + GAIN_W;

   logic [SUM_W-1:0]    clip_sum_ff;
   logic [SUM_W-1:0]    clip_sum_in;
   logic                neg;
   logic [MAG_W-1:0]    mag_in;
   logic [GAIN_W-1:0]   gain;
   logic [PROD_W-1:0]   prod;
   logic [SAMPLE_W-1:0] mag_out;
   logic                over;
   logic [SUM_W:0]      sum_add;
   logic [SUM_W-1:0]    sum_sat;
   logic [SUM_W-1:0]    sum_next;
   logic                clipped;

   // Sign-magnitude multiply: magnitude of -32768 needs the 17th bit.
   assign neg     = sample[SAMPLE_W-1];
   assign mag_in  = neg ? MAG_W'(18'h10000 - 18'(unsigned'(sample)))
                        : MAG_W'(unsigned'(sample));
   assign gain    = gain_lookup(ROM_IDX_W'(gain_step));
   assign prod    = PROD_W'(mag_in) * PROD_W'(gain);
   assign mag_out = prod[30:15];

   assign gained_sample = neg ? SAMPLE_W'(MAG_W'(18'h10000) - MAG_W'(mag_out)) : mag_out;

   assign over     = MAG_W'(mag_out) > MAG_W'(cfg.clip_level);
   assign sum_add  = (SUM_W+1)'(clip_sum_ff) + (SUM_W+1)'(mag_out);
   assign sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign sum_next = over ? sum_sat : clip_sum_ff;
   assign clipped  = frame_end && (sum_next >= cfg.clip_sum_threshold);

   assign clip_sum_in = frame_end ? '0 : sum_next;

   assign frame_event.fire      = fire;
   assign frame_event.frame_end = frame_end;
   assign frame_event.clipped   = clipped;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_sum_ff <= '0;
      end else if (fire) begin
         clip_sum_ff <= clip_sum_in;
      end
   end

endmodule

// ----- rtl/cdgs_step_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdgs_step_ctrl
// Clipped-frame count, hold count, gain index and per-index clip history.
// History sits in two stacks around the current index so that the entries
// at the current and next lower index are always at fixed taps.
// ----------------------------------------------------------------------------
module cdgs_step_ctrl #(
   parameter int NUM_GAINS = cdgs_pkg::NUM_GAINS_DEF,
   localparam int IDX_W    = $clog2(NUM_GAINS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cdgs_pkg::frame_event_type frame_event,
   input  cdgs_pkg::cfg_type         cfg,
   output logic [IDX_W-1:0]          gain_step,
   output logic [IDX_W-1:0]          gain_step_next
);
   import cdgs_pkg::*;

   localparam logic [IDX_W-1:0] TOP = IDX_W'(NUM_GAINS - 1);

   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   // up_ff[0] is history at the current index, up_ff[i] at index + i;
   // dn_ff[0] is history at index - 1, dn_ff[i] at index - 1 - i.
   logic [HIST_W-1:0] up_ff [NUM_GAINS];
   logic [HIST_W-1:0] up_in [NUM_GAINS];
   logic [HIST_W-1:0] dn_ff [NUM_GAINS];
   logic [HIST_W-1:0] dn_in [NUM_GAINS];
   logic [CNT_W-1:0]  cnt_inc;
   logic [HIST_W-1:0] hist_inc;
   logic [HIST_W-1:0] lower_hist;

   assign gain_step      = step_ff;
   assign gain_step_next = step_in;

   assign cnt_inc    = (cnt_ff == {CNT_W{1'b1}}) ? cnt_ff : cnt_ff + 1'b1;
   assign hist_inc   = (up_ff[0] == {HIST_W{1'b1}}) ? up_ff[0] : up_ff[0] + 1'b1;
   assign lower_hist = (step_ff != '0) ? dn_ff[0] : up_ff[0];

   always_comb begin
      cnt_in  = cnt_ff;
      hold_in = hold_ff;
      step_in = step_ff;
      up_in   = up_ff;
      dn_in   = dn_ff;
      if (frame_event.fire && frame_event.frame_end) begin
         if (frame_event.clipped) begin
            if (cnt_inc > cfg.clip_frames_to_step) begin
               cnt_in   = '0;
               hold_in  = cfg.hold_frames;
               up_in[0] = hist_inc;
               if (step_ff != TOP) begin
                  // Step down in gain: push current entry below.
                  step_in  = step_ff + 1'b1;
                  dn_in[0] = hist_inc;
                  for (int i = 1; i < NUM_GAINS; i++) dn_in[i] = dn_ff[i-1];
                  for (int i = 0; i < NUM_GAINS - 1; i++) up_in[i] = up_ff[i+1];
                  up_in[NUM_GAINS-1] = '0;
               end
            end else begin
               cnt_in = cnt_inc;
            end
         end else if (hold_ff != '0) begin
            hold_in = hold_ff - 1'b1;
         end else if (lower_hist <= cfg.history_limit) begin
            hold_in = cfg.hold_frames;
            if (step_ff != '0) begin
               // Step up in gain: pull the lower entry back on top.
               step_in  = step_ff - 1'b1;
               up_in[0] = dn_ff[0];
               for (int i = 1; i < NUM_GAINS; i++) up_in[i] = up_ff[i-1];
               for (int i = 0; i < NUM_GAINS - 1; i++) dn_in[i] = dn_ff[i+1];
               dn_in[NUM_GAINS-1] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         hold_ff <= '0;
         step_ff <= '0;
         for (int i = 0; i < NUM_GAINS; i++) begin
            up_ff[i] <= '0;
            dn_ff[i] <= '0;
         end
      end else begin
         cnt_ff  <= cnt_in;
         hold_ff <= hold_in;
         step_ff <= step_in;
         up_ff   <= up_in;
         dn_ff   <= dn_in;
      end
   end

endmodule

// ----- rtl/clip_driven_gain_stepper.sv -----
// ----------------------------------------------------------------------------
// clip_driven_gain_stepper
// Applies a stepped gain to a Q1.15 sample stream and moves the gain index
// from per-frame clip statistics.
//
// Pipeline: an accepted req beat passes the input register, then one pass
//   of multiply, clip sum and frame update into the result register, from
//   which it leaves as its rsp beat.
// Throughput: 1 beat per cycle unless rsp stalls; the gain/frame state loop closes between beats.
// Reset: synchronous; clears all counters, the gain index, clip history and
//   the valid flags of both pipeline registers, and loads the register reset
//   values.
// ----------------------------------------------------------------------------
module clip_driven_gain_stepper #(
   parameter int NUM_GAINS = cdgs_pkg::NUM_GAINS_DEF
) (
   input logic         clock,
   input logic         reset,
   cdgs_req_if.sink    req_bus,
   cdgs_rsp_if.source  rsp_bus,
   cdgs_csr_if.sink    csr_bus
);
   import cdgs_pkg::*;

   localparam int IDX_W = $clog2(NUM_GAINS);

   // Input register
   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       frame_end_ff;

   // Result register
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] gained_ff;
   logic [ROM_IDX_W-1:0]       index_ff;
   logic                       clipped_ff;

   logic                       advance;
   logic                       fire;
   cfg_type                    cfg;
   frame_event_type            frame_event;
   logic signed [SAMPLE_W-1:0] gained_sample;
   logic [IDX_W-1:0]           gain_step;
   logic [IDX_W-1:0]           gain_step_next;

   // The result register frees up when empty or when its beat is taken;
   // the input register then hands its item through the single pass.
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   cdgs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // Multiply by the gain in force before this item, accumulate clip sum.
   cdgs_gain_path #(.NUM_GAINS(NUM_GAINS)) u_gain_path (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .sample        (sample_ff),
      .frame_end     (frame_end_ff),
      .gain_step     (gain_step),
      .cfg           (cfg),
      .gained_sample (gained_sample),
      .frame_event   (frame_event)
   );

   // Judge the frame and move the gain index at frame end.
   cdgs_step_ctrl #(.NUM_GAINS(NUM_GAINS)) u_step_ctrl (
      .clock          (clock),
      .reset          (reset),
      .frame_event    (frame_event),
      .cfg            (cfg),
      .gain_step      (gain_step),
      .gain_step_next (gain_step_next)
   );

   // Capture an accepted req beat; hold it while the result side stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         sample_ff    <= req_bus.sample;
         frame_end_ff <= req_bus.frame_end;
      end
   end

   // Load the result register on each pass; drop valid once the beat leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         gained_ff  <= gained_sample;
         index_ff   <= ROM_IDX_W'(gain_step_next);
         clipped_ff <= frame_event.clipped;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.gained_sample = gained_ff;
   assign rsp_bus.gain_index    = index_ff;
   assign rsp_bus.frame_clipped = clipped_ff;

endmodule
